// ----- hw/rtl/rsti_pkg.sv -----
// Shared types and constants for the radix string-to-integer unit.
// Holds the item structs, size constants and register indexes; no dependencies.
package rsti_pkg;

   localparam int MAX_CHARS  = 4096;
   localparam int VALUE_BITS = 64;
   localparam int POS_BITS   = $clog2(MAX_CHARS);
   localparam int BASE_BITS  = 6;
   localparam int OFFSET_BITS = 12;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [POS_BITS-1:0] END_MAX = POS_BITS'(MAX_CHARS - 1);
   localparam logic [63:0] VAL_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RADIX       = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIGNED_MODE = CSR_INDEX_BITS'(1);

   localparam logic [BASE_BITS-1:0] RADIX_RESET = BASE_BITS'(10);

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [63:0]            value;
      logic [OFFSET_BITS-1:0] end_offset;
      logic                   any_digit;
   } rsp_item_type;

endpackage

// ----- hw/rtl/radix_string_to_integer_unit.sv -----
// Streaming strtol-style parser: one character per item, one result per string.
// Depends on rsti_pkg for item types, size constants and register indexes.
//
//   channel | direction | handshake               | payload
//   req     | in        | req_valid / req_stall   | req_item (ch, last)
//   rsp     | out       | rsp_valid / rsp_stall   | rsp_item (value, end_offset, any_digit)
//   csr     | in        | csr_valid / csr_ready   | csr_index, csr_wdata
//
// One character per cycle unless a stalled result holds the input register: an item
// waits in the input register, the parse step (one 64x6 multiply-add) runs between it and the result register.
// A character that yields no result moves on even while a result waits.
// Reset (synchronous) empties both registers and restores radix 10, signed mode.
// A stalled result holds the input register only for a character that yields a result.
module radix_string_to_integer_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rsti_pkg::req_item_type           req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rsti_pkg::rsp_item_type           rsp_item,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rsti_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rsti_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rsti_pkg::*;

   localparam logic [2:0] PH_WS     = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_ZERO   = 3'd2;
   localparam logic [2:0] PH_XSEEN  = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;
   localparam logic [2:0] PH_DRAIN  = 3'd5;

   logic [BASE_BITS-1:0]  radix_ff;
   logic                  signed_mode_ff;

   logic                  s1_valid_ff, s1_valid_in;
   req_item_type          s1_item_ff;

   logic [2:0]            phase_ff, phase_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [BASE_BITS-1:0]  base_ff, base_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic                  seen_ff, seen_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_item_ff, rsp_item_in;

   logic                  accept;
   logic                  advance;
   logic                  step_done;

   logic [2:0]            ph_a;
   logic                  neg_a;
   logic                  consumed;
   logic [BASE_BITS-1:0]  base_start;
   logic [BASE_BITS-1:0]  base_use;
   logic                  d_valid;
   logic [5:0]            d_val;
   logic                  take_ok;
   logic [VALUE_BITS-1:0] acc_take;
   logic [VALUE_BITS+BASE_BITS-1:0] product;

   // Character classification, the phase after whitespace and sign handling, and the digit base and multiply-add.
   always_comb begin
      d_valid = 1'b1;
      d_val   = '0;
      if (s1_item_ff.ch inside {[8'h30:8'h39]}) begin
         d_val = 6'(s1_item_ff.ch - 8'h30);
      end else if (s1_item_ff.ch inside {[8'h61:8'h7A]}) begin
         d_val = 6'(s1_item_ff.ch - 8'h61 + 8'd10);
      end else if (s1_item_ff.ch inside {[8'h41:8'h5A]}) begin
         d_val = 6'(s1_item_ff.ch - 8'h41 + 8'd10);
      end else begin
         d_valid = 1'b0;
      end

      ph_a     = phase_ff;
      neg_a    = neg_ff;
      consumed = 1'b0;
      if (phase_ff == PH_WS) begin
         if (s1_item_ff.ch inside {8'h20, [8'h09:8'h0D]}) begin
            ph_a = PH_WS;
         end else if (signed_mode_ff && (s1_item_ff.ch == 8'h2B || s1_item_ff.ch == 8'h2D)) begin
            neg_a    = (s1_item_ff.ch == 8'h2D);
            ph_a     = PH_START;
            consumed = 1'b1;
         end else begin
            ph_a = PH_START;
         end
      end

      base_start = (radix_ff == '0) ? BASE_BITS'(10) : radix_ff;
      case (ph_a)
         PH_START: base_use = base_start;
         PH_ZERO:  base_use = (base_ff == '0) ? BASE_BITS'(8) : base_ff;
         PH_XSEEN: base_use = BASE_BITS'(16);
         default:  base_use = base_ff;
      endcase

      take_ok = d_valid && (base_use >= BASE_BITS'(2)) && (base_use <= BASE_BITS'(36))
                && (d_val < base_use);
      product  = acc_ff * base_use;
      acc_take = VALUE_BITS'(product + (VALUE_BITS + BASE_BITS)'(d_val));
   end

   // Parse step: next state and result of the character in the input register.
   always_comb begin
      logic [POS_BITS:0]   end_w;
      logic [POS_BITS:0]   p_inc;
      logic [POS_BITS-1:0] end_sat;
      logic [63:0]         v;
      logic                is_x;
      logic                is_zero;

      phase_in = ph_a;
      acc_in   = acc_ff;
      neg_in   = neg_a;
      base_in  = base_ff;
      seen_in  = seen_ff;
      step_done = 1'b0;
      end_w    = '0;
      p_inc    = {1'b0, pos_ff} + (POS_BITS+1)'(1);
      is_x     = (s1_item_ff.ch == 8'h78 || s1_item_ff.ch == 8'h58);
      is_zero  = (s1_item_ff.ch == 8'h30);

      if (ph_a == PH_START && !consumed) begin
         if ((radix_ff == '0 || radix_ff == BASE_BITS'(16)) && is_zero) begin
            base_in  = radix_ff;
            acc_in   = '0;
            seen_in  = 1'b1;
            phase_in = PH_ZERO;
         end else begin
            base_in = base_start;
            if (take_ok) begin
               acc_in   = acc_take;
               seen_in  = 1'b1;
               phase_in = PH_DIGITS;
            end else begin
               step_done = 1'b1;
               end_w     = {1'b0, pos_ff};
            end
         end
      end else if (ph_a == PH_ZERO) begin
         if (is_x) begin
            phase_in = PH_XSEEN;
         end else begin
            base_in = base_use;
            if (take_ok) begin
               acc_in   = acc_take;
               seen_in  = 1'b1;
               phase_in = PH_DIGITS;
            end else begin
               step_done = 1'b1;
               end_w     = {1'b0, pos_ff};
            end
         end
      end else if (ph_a == PH_XSEEN) begin
         base_in = base_use;
         if (take_ok) begin
            acc_in   = acc_take;
            seen_in  = 1'b1;
            phase_in = PH_DIGITS;
         end else begin
            step_done = 1'b1;
            end_w     = {1'b0, pos_ff} - (POS_BITS+1)'(1);
         end
      end else if (ph_a == PH_DIGITS) begin
         if (take_ok) begin
            acc_in = acc_take;
         end else begin
            step_done = 1'b1;
            end_w     = {1'b0, pos_ff};
         end
      end

      if (!step_done && s1_item_ff.last && phase_in != PH_DRAIN) begin
         step_done = 1'b1;
         end_w     = (phase_in == PH_XSEEN) ? {1'b0, pos_ff} : p_inc;
      end

      pos_in = (p_inc > {1'b0, END_MAX}) ? END_MAX : POS_BITS'(p_inc);

      end_sat = (end_w > {1'b0, END_MAX}) ? END_MAX : POS_BITS'(end_w);
      v = 64'(acc_in) & VAL_MASK;
      if (neg_in) begin
         v = (64'd0 - v) & VAL_MASK;
      end
      if (signed_mode_ff && v[VALUE_BITS-1]) begin
         v = v | ~VAL_MASK;
      end
      rsp_item_in.any_digit  = seen_in;
      rsp_item_in.value      = seen_in ? v : 64'd0;
      rsp_item_in.end_offset = seen_in ? OFFSET_BITS'(end_sat) : '0;

      if (s1_item_ff.last) begin
         phase_in = PH_WS;
         acc_in   = '0;
         neg_in   = 1'b0;
         base_in  = '0;
         pos_in   = '0;
         seen_in  = 1'b0;
      end else if (step_done) begin
         phase_in = PH_DRAIN;
      end
   end

   assign advance   = s1_valid_ff && (!step_done || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && step_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff       <= RADIX_RESET;
         signed_mode_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_RADIX:       radix_ff       <= csr_wdata[BASE_BITS-1:0];
            CSR_SIGNED_MODE: signed_mode_ff <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_WS;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         base_ff      <= '0;
         pos_ff       <= '0;
         seen_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            neg_ff   <= neg_in;
            base_ff  <= base_in;
            pos_ff   <= pos_in;
            seen_ff  <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
      if (advance && step_done) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_WS && !s1_valid_ff && !rsp_valid_ff))
      else $error("reset left state behind");

   a_drain_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && phase_ff == PH_DRAIN) |-> !step_done)
      else $error("result while draining");

   a_no_digit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.any_digit) |->
         (rsp_item_ff.value == 64'd0 && rsp_item_ff.end_offset == '0))
      else $error("digitless result not zero");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted item lost");

endmodule

// ----- bench/tb_radix_string_to_integer_unit.sv -----
// Self-checking bench for radix_string_to_integer_unit: a short scripted string set,
// then random strings under changing radix and sign settings.
// Depends on rsti_pkg and the unit only; results are checked against an in-bench parser or typed expected values.
module tb_radix_string_to_integer_unit;
   import rsti_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 525;
   localparam int PHASE_ITEMS    = 55;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_2 = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_3 = CSR_INDEX_BITS'(3);

   typedef enum logic [2:0] {
      SKIP_BLANKS, AWAIT_NUMBER, LEAD_ZERO, PREFIX_X, IN_DIGITS, SWALLOW
   } parse_phase_type;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_BITS-1:0]  index;
      logic [7:0]                 data;
      logic                       last;
      rsp_item_type               rsp;
   } script_row_type;

   logic                        clock     = 1'b0;
   logic                        reset     = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   req_item_type                req_item  = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   rsp_item_type                rsp_item;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]    csr_wdata = '0;

   parse_phase_type             st_phase;
   logic [63:0]                 st_acc;
   logic                        st_neg;
   logic [BASE_BITS-1:0]        st_base;
   logic [POS_BITS-1:0]         st_pos;
   logic                        st_seen;
   logic [BASE_BITS-1:0]        cfg_radix;
   logic                        cfg_signed;

   rsp_item_type                pending_numbers[$];
   script_row_type              script[$];
   logic [7:0]                  text_q[$];
   bit                          calm     = 1'b0;
   bit                          typed_on = 1'b0;
   rsp_item_type                typed_rsp;
   int                          errors          = 0;
   int                          chars_sent      = 0;
   int                          numbers_checked = 0;
   int                          csr_writes      = 0;
   int                          idle_cycles     = 0;

   radix_string_to_integer_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void clear_string();
      st_phase = SKIP_BLANKS;
      st_acc   = '0;
      st_neg   = 1'b0;
      st_base  = '0;
      st_pos   = '0;
      st_seen  = 1'b0;
   endfunction

   function automatic bit take_digit(input logic [7:0] ch);
      logic [6:0] d;
      d = 7'd99;
      if (ch >= "0" && ch <= "9") d = 7'(ch - "0");
      else if (ch >= "a" && ch <= "z") d = 7'(ch - "a" + 10);
      else if (ch >= "A" && ch <= "Z") d = 7'(ch - "A" + 10);
      if (st_base < 2 || st_base > 36 || d >= 7'(st_base)) return 1'b0;
      st_acc   = (st_acc * 64'(st_base) + 64'(d)) & VAL_MASK;
      st_seen  = 1'b1;
      st_phase = IN_DIGITS;
      return 1'b1;
   endfunction

   function automatic bit parse_char(input req_item_type it, output rsp_item_type res);
      logic [POS_BITS-1:0] p;
      logic [POS_BITS:0]   stop;
      bit                  done;
      bit                  sign_used;
      p         = st_pos;
      stop      = '0;
      done      = 1'b0;
      sign_used = 1'b0;
      res       = '0;
      if (st_phase == SKIP_BLANKS && !(it.ch == 8'h20 || (it.ch >= 8'h09 && it.ch <= 8'h0D))) begin
         if (cfg_signed && (it.ch == "+" || it.ch == "-")) begin
            st_neg    = (it.ch == "-");
            sign_used = 1'b1;
         end
         st_phase = AWAIT_NUMBER;
      end
      if (!sign_used) begin
         case (st_phase)
            AWAIT_NUMBER: begin
               if ((cfg_radix == 0 || cfg_radix == 16) && it.ch == "0") begin
                  st_base  = cfg_radix;
                  st_acc   = '0;
                  st_seen  = 1'b1;
                  st_phase = LEAD_ZERO;
               end else begin
                  st_base = (cfg_radix == 0) ? BASE_BITS'(10) : cfg_radix;
                  if (!take_digit(it.ch)) begin
                     done = 1'b1;
                     stop = {1'b0, p};
                  end
               end
            end
            LEAD_ZERO: begin
               if (it.ch == "x" || it.ch == "X") begin
                  st_phase = PREFIX_X;
               end else begin
                  if (st_base == 0) st_base = BASE_BITS'(8);
                  if (!take_digit(it.ch)) begin
                     done = 1'b1;
                     stop = {1'b0, p};
                  end
               end
            end
            PREFIX_X: begin
               st_base = BASE_BITS'(16);
               if (!take_digit(it.ch)) begin
                  done = 1'b1;
                  stop = {1'b0, p} - 1'b1;
               end
            end
            IN_DIGITS: begin
               if (!take_digit(it.ch)) begin
                  done = 1'b1;
                  stop = {1'b0, p};
               end
            end
            default: ;
         endcase
      end
      if (!done && it.last && st_phase != SWALLOW) begin
         done = 1'b1;
         stop = (st_phase == PREFIX_X) ? {1'b0, p} : {1'b0, p} + 1'b1;
      end
      st_pos = (p == END_MAX) ? p : p + 1'b1;
      if (done) begin
         if (st_seen) begin
            res.value      = st_neg ? (64'd0 - st_acc) & VAL_MASK : st_acc;
            res.end_offset = (stop > END_MAX) ? END_MAX : stop[POS_BITS-1:0];
         end
         res.any_digit = st_seen;
         if (!it.last) st_phase = SWALLOW;
      end
      if (it.last) clear_string();
      return done;
   endfunction

   function automatic logic [7:0] blank_char();
      int v;
      v = $urandom_range(8, 13);
      return (v == 8) ? 8'h20 : 8'(v);
   endfunction

   function automatic script_row_type mk_row(input row_kind_type kind,
                                             input logic [CSR_INDEX_BITS-1:0] index,
                                             input logic [7:0] data, input logic last,
                                             input logic [63:0] value,
                                             input logic [OFFSET_BITS-1:0] off,
                                             input logic any);
      script_row_type r;
      r.kind           = kind;
      r.index          = index;
      r.data           = data;
      r.last           = last;
      r.rsp.value      = value;
      r.rsp.end_offset = off;
      r.rsp.any_digit  = any;
      return r;
   endfunction

   // hold each item until taken; idle at random before it
   task automatic send_char(input logic [7:0] ch, input logic last);
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= req_item_type'({ch, last});
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
   endtask

   // drain all results, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_numbers.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx, input logic [7:0] data);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed numbers for the current radix, some raw noise
   task automatic fill_text();
      int  b;
      int  d;
      bit  zero_lead;
      bit  hex_lead;
      text_q.delete();
      if ($urandom_range(0, 99) < 15) begin
         repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom));
         return;
      end
      repeat ($urandom_range(0, 3)) text_q.push_back(blank_char());
      if ($urandom_range(0, 1)) text_q.push_back($urandom_range(0, 1) ? 8'h2D : 8'h2B);
      zero_lead = $urandom_range(0, 99) < 30;
      hex_lead  = zero_lead && $urandom_range(0, 1);
      if (zero_lead) text_q.push_back("0");
      if (hex_lead) text_q.push_back($urandom_range(0, 1) ? 8'h78 : 8'h58);
      b = cfg_radix;
      if (hex_lead && (b == 0 || b == 16)) b = 16;
      else if (b == 0) b = zero_lead ? 8 : 10;
      if (b < 2 || b > 36) b = 10;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(0, 5)) begin
         d = $urandom_range(0, b - 1);
         if (d < 10) text_q.push_back(8'("0" + d));
         else if ($urandom_range(0, 1)) text_q.push_back(8'("A" + d - 10));
         else text_q.push_back(8'("a" + d - 10));
      end
      if ($urandom_range(0, 1) || text_q.size() == 0)
         repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom));
   endtask

   always @(negedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 16);
   end

   always @(posedge clock) begin : watch
      rsp_item_type got;
      rsp_item_type want;
      bit           moved;
      if (reset) begin
         cfg_radix   = RADIX_RESET;
         cfg_signed  = 1'b1;
         idle_cycles = 0;
         clear_string();
      end else begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            csr_writes++;
            case (csr_index)
               CSR_RADIX:       cfg_radix  = csr_wdata[BASE_BITS-1:0];
               CSR_SIGNED_MODE: cfg_signed = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            chars_sent++;
            if (parse_char(req_item, got) && !typed_on) pending_numbers.push_back(got);
            if (typed_on) pending_numbers.push_back(typed_rsp);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got   = rsp_item;
            if (pending_numbers.size() == 0) begin
               errors++;
               $display("%0t: unexpected result value %h end_offset %0d any_digit %0b",
                        $time, got.value, got.end_offset, got.any_digit);
            end else begin
               want = pending_numbers.pop_front();
               numbers_checked++;
               if (got.value != want.value) begin
                  errors++;
                  $display("%0t: value expected %h got %h", $time, want.value, got.value);
               end
               if (got.end_offset != want.end_offset) begin
                  errors++;
                  $display("%0t: end_offset expected %0d got %0d",
                           $time, want.end_offset, got.end_offset);
               end
               if (got.any_digit != want.any_digit) begin
                  errors++;
                  $display("%0t: any_digit expected %0b got %0b",
                           $time, want.any_digit, got.any_digit);
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_radix_string_to_integer_unit failed");
            $finish;
         end
      end
   end

   initial begin
      int                   k;
      int                   phase_items;
      int                   random_items;
      logic [BASE_BITS-1:0] r;
      logic                 sgn;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      script.push_back(mk_row(ROW_PREDICT, '0, " ", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "-", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "4", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "2", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_TYPED, '0, "z", 1'b1, 64'hFFFF_FFFF_FFFF_FFD6, 12'd4, 1'b1));
      script.push_back(mk_row(ROW_TYPED, '0, 8'hFF, 1'b1, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_TYPED, '0, 8'h00, 1'b1, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_CSR, CSR_RADIX, 8'hC0, 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "0", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "x", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_TYPED, '0, "g", 1'b0, '0, 12'd1, 1'b1));
      script.push_back(mk_row(ROW_PREDICT, '0, "5", 1'b1, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "0", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "X", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "F", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_TYPED, '0, "f", 1'b1, 64'd255, 12'd4, 1'b1));
      script.push_back(mk_row(ROW_PREDICT, '0, "0", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "7", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_TYPED, '0, "8", 1'b1, 64'd7, 12'd2, 1'b1));
      script.push_back(mk_row(ROW_CSR, CSR_SIGNED_MODE, 8'hFE, 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_CSR, CSR_RADIX, 8'd36, 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_TYPED, '0, "+", 1'b1, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "Z", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_TYPED, '0, "z", 1'b1, 64'd1295, 12'd2, 1'b1));
      script.push_back(mk_row(ROW_CSR, CSR_RADIX, 8'd1, 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_TYPED, '0, "0", 1'b1, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_CSR, CSR_SPARE_3, 8'hFF, 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, 8'h0B, 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_CSR, CSR_RADIX, 8'd2, 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_CSR, CSR_SIGNED_MODE, 8'd1, 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "-", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_PREDICT, '0, "1", 1'b0, '0, '0, 1'b0));
      script.push_back(mk_row(ROW_TYPED, '0, "1", 1'b1, 64'hFFFF_FFFF_FFFF_FFFD, 12'd4, 1'b1));

      foreach (script[i]) begin
         case (script[i].kind)
            ROW_CSR: write_csr(script[i].index, script[i].data);
            ROW_TYPED: begin
               typed_rsp = script[i].rsp;
               typed_on  = 1'b1;
               send_char(script[i].data, script[i].last);
               typed_on  = 1'b0;
            end
            default: send_char(script[i].data, script[i].last);
         endcase
      end

      k            = 0;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (k)
            0:       r = BASE_BITS'(0);
            1:       r = BASE_BITS'(16);
            2:       r = BASE_BITS'(36);
            3:       r = BASE_BITS'(2);
            4:       r = BASE_BITS'(8);
            5:       r = BASE_BITS'(63);
            6:       r = BASE_BITS'(1);
            7:       r = BASE_BITS'(10);
            8:       r = BASE_BITS'(37);
            default: r = BASE_BITS'($urandom_range(0, 36));
         endcase
         sgn = (k < 8) ? k[0] : 1'($urandom);
         write_csr(CSR_RADIX, {2'($urandom), r});
         write_csr(CSR_SIGNED_MODE, {7'($urandom), sgn});
         if ($urandom_range(0, 2) == 0)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, 8'($urandom));
         calm        = (k == 3);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
            fill_text();
            send_text();
            phase_items  += text_q.size();
            random_items += text_q.size();
         end
         k++;
      end
      calm = 1'b0;
      settle();

      $display("covered %0d characters over %0d radix/sign settings, %0d register writes,",
               chars_sent, k + 7, csr_writes);
      $display("%0d parsed numbers checked", numbers_checked);
      if (errors == 0 && pending_numbers.size() == 0) begin
         $display("tb_radix_string_to_integer_unit passed");
      end else begin
         $display("tb_radix_string_to_integer_unit failed");
      end
      $finish;
   end

endmodule
